// ----- rtl/srrw_pkg.sv -----
// Shared types and constants for the selective-repeat receive window.
package srrw_pkg;

	localparam int SEQ_W     = 16;
	localparam int PAYLOAD_W = 64;
	localparam int NBYTES_W  = 4;
	localparam int TDATA_W   = 88;
	localparam int OUSER_W   = 3;

	localparam logic KIND_ACK  = 1'b0;
	localparam logic KIND_DATA = 1'b1;

	typedef struct packed {
		logic capture;
		logic store;
		logic adv;
		logic emit_ack;
		logic ack_last;
		logic clr_idx;
		logic emit_chunk;
		logic inc_idx;
		logic slide;
	} cmd_t;

	typedef struct packed {
		logic active;
		logic in_win;
		logic storable;
		logic adv_ok;
		logic deliver;
		logic chunk_last;
		logic out_free;
	} sts_t;

	typedef struct packed {
		logic                 kind;
		logic                 relay;
		logic [SEQ_W-1:0]     seq;
		logic [PAYLOAD_W-1:0] data;
		logic [NBYTES_W-1:0]  nbytes;
		logic                 done;
		logic                 last;
	} res_t;

endpackage

// ----- rtl/srrw_ctrl.sv -----
// Sequencing state machine for the selective-repeat receive window.
module srrw_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  srrw_pkg::sts_t sts,
	output srrw_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ADV,
		ST_ACK,
		ST_RD,
		ST_EMIT
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.capture = in_valid;
			end
			ST_CHECK: begin
				cmd.store = sts.active && sts.storable;
			end
			ST_ADV: begin
				cmd.adv = sts.adv_ok;
			end
			ST_ACK: begin
				cmd.emit_ack = sts.out_free;
				cmd.ack_last = !(sts.in_win && sts.deliver);
				cmd.clr_idx  = sts.out_free;
			end
			ST_EMIT: begin
				cmd.emit_chunk = sts.out_free;
				cmd.slide      = sts.out_free && sts.chunk_last;
				cmd.inc_idx    = sts.out_free && !sts.chunk_last;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (!sts.active) state_q <= ST_IDLE;
					else if (sts.in_win) state_q <= ST_ADV;
					else state_q <= ST_ACK;
				end
				ST_ADV: begin
					if (!sts.adv_ok) state_q <= ST_ACK;
				end
				ST_ACK: begin
					if (sts.out_free) begin
						if (sts.in_win && sts.deliver) state_q <= ST_RD;
						else state_q <= ST_IDLE;
					end
				end
				ST_RD: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (sts.out_free) begin
						if (sts.chunk_last) state_q <= ST_IDLE;
						else state_q <= ST_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/srrw_dpath.sv -----
// Window state, slot store and result register for the selective-repeat receive window.
module srrw_dpath #(
	parameter int WINDOW      = 8,
	parameter int CHUNK_BYTES = 8,
	parameter int SEQ_BITS    = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_relay,
	input  logic [srrw_pkg::SEQ_W-1:0]           in_seq,
	input  logic [srrw_pkg::PAYLOAD_W-1:0]       in_payload,
	input  logic [srrw_pkg::NBYTES_W-1:0]        in_nbytes,
	input  logic                                 in_final,
	input  srrw_pkg::cmd_t                       cmd,
	output srrw_pkg::sts_t                       sts,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output srrw_pkg::res_t                       out_res
);

	localparam int IW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CW     = $clog2(WINDOW + 1);
	localparam int HALF_W = WINDOW / 2;
	localparam int NB     = srrw_pkg::PAYLOAD_W / 8;

	function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] head,
		input logic [CW-1:0] k);
		logic [CW:0] s;
		s = (CW+1)'(head) + (CW+1)'(k);
		if (s >= (CW+1)'(WINDOW)) s = s - (CW+1)'(WINDOW);
		return IW'(s);
	endfunction

	// Captured packet.
	logic                              relay_q;
	logic [SEQ_BITS-1:0]               seq_q;
	logic [srrw_pkg::PAYLOAD_W-1:0]    pay_q;
	logic [srrw_pkg::NBYTES_W-1:0]     nb_q;
	logic                              fin_q;

	// Window state.
	logic [SEQ_BITS-1:0]               base_q;
	logic [CW-1:0]                     cnt_q;
	logic [IW-1:0]                     head_q;
	logic [WINDOW-1:0]                 rcv_q;
	logic [CW-1:0]                     idx_q;
	logic [SEQ_BITS-1:0]               final_seq_q;
	logic                              final_seen_q;
	logic [srrw_pkg::NBYTES_W-1:0]     final_bytes_q;
	logic                              finished_q;

	logic [srrw_pkg::PAYLOAD_W-1:0]    mem_q [WINDOW];
	logic [srrw_pkg::PAYLOAD_W-1:0]    rd_q;

	logic                              out_valid_q;
	srrw_pkg::res_t                    out_res_q;

	logic [srrw_pkg::NBYTES_W-1:0]     nb_sat;
	logic [srrw_pkg::PAYLOAD_W-1:0]    pay_masked;
	logic [SEQ_BITS-1:0]               diff;
	logic [SEQ_BITS-1:0]               fdiff;
	logic [CW-1:0]                     diff_k;
	logic                              in_win;
	logic                              below;
	logic                              fin;
	logic                              chunk_final;
	logic                              out_free;
	logic                              load;
	srrw_pkg::res_t                    res_next;

	always_comb begin
		if (in_nbytes > srrw_pkg::NBYTES_W'(CHUNK_BYTES)) nb_sat = srrw_pkg::NBYTES_W'(CHUNK_BYTES);
		else nb_sat = in_nbytes;
		for (int b = 0; b < NB; b++) begin
			pay_masked[8*b +: 8] = (srrw_pkg::NBYTES_W'(b) < nb_sat) ? in_payload[8*b +: 8] : 8'h00;
		end
	end

	assign diff        = seq_q - base_q;
	assign in_win      = diff < SEQ_BITS'(WINDOW);
	assign below       = diff[SEQ_BITS-1];
	assign diff_k      = CW'(diff);
	assign fdiff       = final_seq_q - base_q;
	assign fin         = final_seen_q && (fdiff < SEQ_BITS'(cnt_q));
	assign chunk_final = fin && (SEQ_BITS'(idx_q) == fdiff);
	assign out_free    = !out_valid_q || out_ready;

	always_comb begin
		sts.active     = !finished_q && (in_win || below);
		sts.in_win     = in_win;
		sts.storable   = in_win && (diff_k >= cnt_q);
		sts.adv_ok     = (cnt_q < CW'(WINDOW)) && rcv_q[slot_of(head_q, cnt_q)];
		sts.deliver    = (cnt_q >= CW'(HALF_W)) || fin;
		sts.chunk_last = (idx_q == cnt_q - CW'(1)) || chunk_final;
		sts.out_free   = out_free;
	end

	always_comb begin
		res_next = '0;
		if (cmd.emit_chunk) begin
			res_next.kind   = srrw_pkg::KIND_DATA;
			res_next.seq    = srrw_pkg::SEQ_W'(base_q + SEQ_BITS'(idx_q));
			res_next.data   = rd_q;
			res_next.nbytes = chunk_final ? final_bytes_q : srrw_pkg::NBYTES_W'(CHUNK_BYTES);
			res_next.done   = chunk_final;
			res_next.last   = sts.chunk_last;
		end else begin
			res_next.kind  = srrw_pkg::KIND_ACK;
			res_next.relay = relay_q;
			res_next.seq   = srrw_pkg::SEQ_W'(seq_q);
			res_next.last  = cmd.ack_last;
		end
	end

	assign load = cmd.emit_ack || cmd.emit_chunk;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			relay_q <= in_relay;
			seq_q   <= SEQ_BITS'(in_seq);
			pay_q   <= pay_masked;
			nb_q    <= nb_sat;
			fin_q   <= in_final;
		end
		if (cmd.store) mem_q[slot_of(head_q, diff_k)] <= pay_q;
		rd_q <= mem_q[slot_of(head_q, idx_q)];
		if (load) out_res_q <= res_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q        <= '0;
			cnt_q         <= '0;
			head_q        <= '0;
			rcv_q         <= '0;
			idx_q         <= '0;
			final_seq_q   <= '0;
			final_seen_q  <= 1'b0;
			final_bytes_q <= '0;
			finished_q    <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.store) begin
				rcv_q[slot_of(head_q, diff_k)] <= 1'b1;
				if (fin_q) begin
					final_seq_q   <= seq_q;
					final_seen_q  <= 1'b1;
					final_bytes_q <= nb_q;
				end
			end
			if (cmd.adv) cnt_q <= cnt_q + CW'(1);
			if (cmd.clr_idx) idx_q <= '0;
			if (cmd.inc_idx) idx_q <= idx_q + CW'(1);
			if (cmd.emit_chunk) rcv_q[slot_of(head_q, idx_q)] <= 1'b0;
			if (cmd.slide) begin
				base_q <= base_q + SEQ_BITS'(cnt_q);
				head_q <= slot_of(head_q, cnt_q);
				cnt_q  <= '0;
				if (fin) finished_q <= 1'b1;
			end
			if (load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

endmodule

// ----- rtl/selective_repeat_receive_window.sv -----
// Selective-repeat receive window: acknowledges received packets and delivers chunks in order.
// Each accepted packet is first captured and then checked against the window; a packet inside
// the window then goes through the in-order scan, which passes each newly received slot in
// turn, and every acknowledged packet then places its acknowledgement in the output register.
// When the window slides, each delivered chunk goes through the registered read of the slot
// store followed by the output register load. A packet beyond the window or after the stream
// has finished is dropped after the check; an acknowledged packet that lies below the window
// goes from the check straight to its acknowledgement and slides nothing. Back-pressure on the
// output stalls the acknowledgement and each chunk load. The output register lets the next
// packet be taken while a result waits.
module selective_repeat_receive_window #(
	parameter int WINDOW      = 8,
	parameter int CHUNK_BYTES = 8,
	parameter int SEQ_BITS    = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// seq [15:0], payload [79:16], payload_bytes [83:80], zero [87:84]
	input  logic [srrw_pkg::TDATA_W-1:0]   s_axis_tdata,
	// relay [0]
	input  logic                           s_axis_tuser,
	input  logic                           s_axis_tlast,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// ack_seq [15:0], data_out [79:16], data_bytes [83:80], zero [87:84]
	output logic [srrw_pkg::TDATA_W-1:0]   m_axis_tdata,
	// kind [0], ack_relay [1], stream_done [2]
	output logic [srrw_pkg::OUSER_W-1:0]   m_axis_tuser,
	output logic                           m_axis_tlast
);

	srrw_pkg::cmd_t cmd;
	srrw_pkg::sts_t sts;
	srrw_pkg::res_t res;

	srrw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	srrw_dpath #(
		.WINDOW      (WINDOW),
		.CHUNK_BYTES (CHUNK_BYTES),
		.SEQ_BITS    (SEQ_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_relay   (s_axis_tuser),
		.in_seq     (s_axis_tdata[15:0]),
		.in_payload (s_axis_tdata[79:16]),
		.in_nbytes  (s_axis_tdata[83:80]),
		.in_final   (s_axis_tlast),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_res    (res)
	);

	assign m_axis_tdata = {4'h0, res.nbytes, res.data, res.seq};
	assign m_axis_tuser = {res.done, res.relay, res.kind};
	assign m_axis_tlast = res.last;

endmodule

// ----- rtl/srrw_checker.sv -----
// Port-level checks for the selective-repeat receive window, bound to the top level.
module srrw_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [srrw_pkg::TDATA_W-1:0]   m_axis_tdata,
	input  logic [srrw_pkg::OUSER_W-1:0]   m_axis_tuser,
	input  logic                           m_axis_tlast
);

	// A stalled result request holds its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
	else $error("stalled result changed");

	// Acknowledgements carry no chunk, no length and no end-of-stream mark.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser[0] == srrw_pkg::KIND_ACK)
		|-> (m_axis_tdata[87:16] == '0) && !m_axis_tuser[2])
	else $error("acknowledgement carries data");

	// Delivered chunks never name a relay.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser[0] == srrw_pkg::KIND_DATA) |-> !m_axis_tuser[1])
	else $error("data chunk carries a relay");

	// The chunk that ends the stream is the last result of its packet and carries at most eight bytes.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tlast && (m_axis_tdata[83:80] <= 4'd8))
	else $error("end of stream not at end of run");

endmodule

bind selective_repeat_receive_window srrw_checker u_srrw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
